/* hdl/lsmd_pkg.sv */
// ============================================================================
// lsmd_pkg
// Shared types and constants for the line sensor median detector.
// ============================================================================
package lsmd_pkg;

    // Channel geometry
    localparam int CHANNELS = 8;
    localparam int DATA_W   = 8;

    // Configuration port
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 4;

    // Register reset values
    localparam logic [DATA_W-1:0] LINE_THR_RST = 8'd20;
    localparam logic [DATA_W-1:0] FWD_THR_RST  = 8'd30;
    localparam logic              FWD_EN_RST   = 1'b1;

    // Ranks of the two middle filtered values that form the level
    localparam int LEVEL_LO_RANK = 3;
    localparam int LEVEL_HI_RANK = 4;

    // Register indexes (word address bits [3:2])
    typedef enum logic [1:0] {
        REG_LINE_THR = 2'd0,
        REG_FWD_THR  = 2'd1,
        REG_FWD_EN   = 2'd2
    } t_reg_idx;

    // Configuration values seen by the datapath
    typedef struct packed {
        logic [DATA_W-1:0] line_thr;
        logic [DATA_W-1:0] fwd_thr;
        logic              fwd_en;
    } t_cfg;

    // Pipeline load strobes, shared by all lanes and the merge stage
    typedef struct packed {
        logic shift;  // round transfer: shift reading into the round line
        logic ld1;    // final round: snapshot the full set of readings
        logic ld2;    // median select
        logic ld3;    // history push and sum
        logic ld4;    // divide by history depth
        logic ld5;    // middle pair select
        logic ld6;    // level, mask and result register
    } t_pipe_ctl;

endpackage

/* hdl/lsmd_intf.sv */
// ============================================================================
// lsmd_intf
// Valid/ready channels for scan rounds and for detection results.
// ============================================================================
interface lsmd_in_if;
    logic                          valid;
    logic                          ready;
    logic [lsmd_pkg::DATA_W-1:0]   ch0;
    logic [lsmd_pkg::DATA_W-1:0]   ch1;
    logic [lsmd_pkg::DATA_W-1:0]   ch2;
    logic [lsmd_pkg::DATA_W-1:0]   ch3;
    logic [lsmd_pkg::DATA_W-1:0]   ch4;
    logic [lsmd_pkg::DATA_W-1:0]   ch5;
    logic [lsmd_pkg::DATA_W-1:0]   ch6;
    logic [lsmd_pkg::DATA_W-1:0]   ch7;

    modport source (output valid, ch0, ch1, ch2, ch3, ch4, ch5, ch6, ch7, input ready);
    modport sink   (input valid, ch0, ch1, ch2, ch3, ch4, ch5, ch6, ch7, output ready);
endinterface

interface lsmd_out_if;
    logic                          valid;
    logic                          ready;
    logic [lsmd_pkg::DATA_W-1:0]   line_mask;
    logic [lsmd_pkg::DATA_W-1:0]   level;
    logic [lsmd_pkg::DATA_W-1:0]   f0;
    logic [lsmd_pkg::DATA_W-1:0]   f1;
    logic [lsmd_pkg::DATA_W-1:0]   f2;
    logic [lsmd_pkg::DATA_W-1:0]   f3;
    logic [lsmd_pkg::DATA_W-1:0]   f4;
    logic [lsmd_pkg::DATA_W-1:0]   f5;
    logic [lsmd_pkg::DATA_W-1:0]   f6;
    logic [lsmd_pkg::DATA_W-1:0]   f7;

    modport source (output valid, line_mask, level, f0, f1, f2, f3, f4, f5, f6, f7,
                    input ready);
    modport sink   (input valid, line_mask, level, f0, f1, f2, f3, f4, f5, f6, f7,
                    output ready);
endinterface

/* hdl/line_sensor_median_detector_core.sv */
// The last round of a measurement reaches its result through six registered stages.
// Throughput: one round per cycle; one result every ROUNDS_PER_MEASURE rounds.
// The input stalls only when all six pipeline stages hold results behind a
// stalled output; stage ranking and median selection set the clock path.
// Reset (synchronous, active low) clears the round count, the stage valids,
// the median history and restores register defaults.
// ============================================================================
// line_sensor_median_detector_core
// Eight-lane median and moving-average filter with middle-pair line detection.
// ============================================================================
module line_sensor_median_detector_core #(
    parameter int ROUNDS_PER_MEASURE = 5,
    parameter int AVERAGE_DEPTH      = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lsmd_in_if.sink                        i_in,
    lsmd_out_if.source                     o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsmd_pkg::PADDR_W-1:0]   paddr,
    input  logic [lsmd_pkg::APB_DW-1:0]    pwdata,
    output logic [lsmd_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    localparam int NCH   = lsmd_pkg::CHANNELS;
    localparam int DW    = lsmd_pkg::DATA_W;
    localparam int CNT_W = (ROUNDS_PER_MEASURE > 1) ? $clog2(ROUNDS_PER_MEASURE) : 1;

    lsmd_pkg::t_cfg      w_cfg;
    lsmd_pkg::t_pipe_ctl w_ctl;
    logic [CNT_W-1:0]    r_cnt;
    logic                w_last;
    logic                w_acc;
    logic                r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic                w_m1, w_m2, w_m3, w_m4, w_m5, w_m6;
    logic [DW-1:0]       w_raw  [NCH];
    logic [DW-1:0]       w_filt [NCH];
    logic [DW-1:0]       w_fout [NCH];

    // Configuration registers
    lsmd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Stall chain: a stage may load when it is empty or moving on
    assign w_m6 = !r_v6 || o_res.ready;
    assign w_m5 = !r_v5 || (r_v5 && w_m6);
    assign w_m4 = !r_v4 || (r_v4 && w_m5);
    assign w_m3 = !r_v3 || (r_v3 && w_m4);
    assign w_m2 = !r_v2 || (r_v2 && w_m3);
    assign w_m1 = !r_v1 || (r_v1 && w_m2);

    assign i_in.ready = w_m1;
    assign w_acc      = i_in.valid && w_m1;
    assign w_last     = (r_cnt == CNT_W'(ROUNDS_PER_MEASURE - 1));

    assign w_ctl.shift = w_acc;
    assign w_ctl.ld1   = w_acc && w_last;
    assign w_ctl.ld2   = r_v1 && w_m2;
    assign w_ctl.ld3   = r_v2 && w_m3;
    assign w_ctl.ld4   = r_v3 && w_m4;
    assign w_ctl.ld5   = r_v4 && w_m5;
    assign w_ctl.ld6   = r_v5 && w_m6;

    // Round count and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_cnt <= w_last ? '0 : r_cnt + CNT_W'(1);
            end
            r_v1 <= w_ctl.ld1 || (r_v1 && !w_ctl.ld2);
            r_v2 <= w_ctl.ld2 || (r_v2 && !w_ctl.ld3);
            r_v3 <= w_ctl.ld3 || (r_v3 && !w_ctl.ld4);
            r_v4 <= w_ctl.ld4 || (r_v4 && !w_ctl.ld5);
            r_v5 <= w_ctl.ld5 || (r_v5 && !w_ctl.ld6);
            r_v6 <= w_ctl.ld6 || (r_v6 && !o_res.ready);
        end
    end

    // Unpack readings
    assign w_raw[0] = i_in.ch0;
    assign w_raw[1] = i_in.ch1;
    assign w_raw[2] = i_in.ch2;
    assign w_raw[3] = i_in.ch3;
    assign w_raw[4] = i_in.ch4;
    assign w_raw[5] = i_in.ch5;
    assign w_raw[6] = i_in.ch6;
    assign w_raw[7] = i_in.ch7;

    // Per-channel lanes
    generate
        for (genvar c = 0; c < NCH; c++) begin : g_lane
            lsmd_lane #(
                .ROUNDS_PER_MEASURE (ROUNDS_PER_MEASURE),
                .AVERAGE_DEPTH      (AVERAGE_DEPTH)
            ) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_raw   (w_raw[c]),
                .o_filt  (w_filt[c])
            );
        end
    endgenerate

    // Merge and result register
    lsmd_merge u_merge (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_cfg   (w_cfg),
        .i_filt  (w_filt),
        .o_mask  (o_res.line_mask),
        .o_level (o_res.level),
        .o_filt  (w_fout)
    );

    assign o_res.valid = r_v6;
    assign o_res.f0    = w_fout[0];
    assign o_res.f1    = w_fout[1];
    assign o_res.f2    = w_fout[2];
    assign o_res.f3    = w_fout[3];
    assign o_res.f4    = w_fout[4];
    assign o_res.f5    = w_fout[5];
    assign o_res.f6    = w_fout[6];
    assign o_res.f7    = w_fout[7];

    // Round count stays within one measurement
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ROUNDS_PER_MEASURE - 1))
        else $error("round count out of range");

    // Input only stalls when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_v6))
        else $error("input stalled with a free stage");

    // Last round of a measurement always enters the pipeline
    a_last_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last) |=> r_v1)
        else $error("final round transfer lost");

    // Forward channel masked when forward use is off
    a_fwd_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !w_cfg.fwd_en) |-> !o_res.line_mask[0])
        else $error("forward channel flagged while disabled");

endmodule

/* hdl/lsmd_regs.sv */
// ============================================================================
// lsmd_regs
// APB-style configuration registers: thresholds and forward enable.
// ============================================================================
module lsmd_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsmd_pkg::PADDR_W-1:0]   paddr,
    input  logic [lsmd_pkg::APB_DW-1:0]    pwdata,
    output logic [lsmd_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output lsmd_pkg::t_cfg                 o_cfg
);

    logic [lsmd_pkg::DATA_W-1:0] r_line_thr;
    logic [lsmd_pkg::DATA_W-1:0] r_fwd_thr;
    logic                        r_fwd_en;
    logic                        w_wr;
    lsmd_pkg::t_reg_idx          w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = lsmd_pkg::t_reg_idx'(paddr[3:2]);

    // Register writes; unmapped index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_thr <= lsmd_pkg::LINE_THR_RST;
            r_fwd_thr  <= lsmd_pkg::FWD_THR_RST;
            r_fwd_en   <= lsmd_pkg::FWD_EN_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                lsmd_pkg::REG_LINE_THR: r_line_thr <= pwdata[lsmd_pkg::DATA_W-1:0];
                lsmd_pkg::REG_FWD_THR:  r_fwd_thr  <= pwdata[lsmd_pkg::DATA_W-1:0];
                lsmd_pkg::REG_FWD_EN:   r_fwd_en   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            lsmd_pkg::REG_LINE_THR: prdata = lsmd_pkg::APB_DW'(r_line_thr);
            lsmd_pkg::REG_FWD_THR:  prdata = lsmd_pkg::APB_DW'(r_fwd_thr);
            lsmd_pkg::REG_FWD_EN:   prdata = lsmd_pkg::APB_DW'(r_fwd_en);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = '{line_thr: r_line_thr, fwd_thr: r_fwd_thr, fwd_en: r_fwd_en};

endmodule

/* hdl/lsmd_lane.sv */
// ============================================================================
// lsmd_lane
// One channel: round line, median of the rounds, median history and average.
// ============================================================================
module lsmd_lane #(
    parameter int ROUNDS_PER_MEASURE = 5,
    parameter int AVERAGE_DEPTH      = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsmd_pkg::t_pipe_ctl           i_ctl,
    input  logic [lsmd_pkg::DATA_W-1:0]   i_raw,
    output logic [lsmd_pkg::DATA_W-1:0]   o_filt
);

    localparam int R      = ROUNDS_PER_MEASURE;
    localparam int D      = AVERAGE_DEPTH;
    localparam int DW     = lsmd_pkg::DATA_W;
    localparam int RK_W   = $clog2(R + 1);
    localparam int SUM_W  = DW + $clog2(D);
    // floor(s / D) == (s * FM) >> FK for every s below 2**SUM_W
    localparam int FK     = SUM_W + $clog2(D);
    localparam int PROD_W = FK + DW;
    localparam logic [FK:0] FM = (FK + 1)'(((2 ** FK) + D - 1) / D);

    logic [DW-1:0]     w_round [R];
    logic [DW-1:0]     r_snap  [R];
    logic [DW-1:0]     w_med;
    logic [DW-1:0]     r_med;
    logic [DW-1:0]     r_hist  [D];
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0] w_prod;
    logic [DW-1:0]     r_filt;

    // Round line: earlier rounds of the measurement, current reading appended
    generate
        if (R > 1) begin : g_store
            logic [DW-1:0] r_store [R-1];

            always_ff @(posedge i_clk) begin
                if (i_ctl.shift) begin
                    r_store[0] <= i_raw;
                    for (int k = 1; k < R - 1; k++) begin
                        r_store[k] <= r_store[k-1];
                    end
                end
            end

            always_comb begin
                for (int k = 0; k < R - 1; k++) begin
                    w_round[k] = r_store[k];
                end
                w_round[R-1] = i_raw;
            end
        end else begin : g_single
            assign w_round[0] = i_raw;
        end
    endgenerate

    // Stage 1: snapshot of all rounds
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_snap <= w_round;
        end
    end

    // Stage 2: median by rank; ties broken by position so ranks are unique
    always_comb begin
        logic [RK_W-1:0] v_rank;
        w_med = '0;
        for (int i = 0; i < R; i++) begin
            v_rank = '0;
            for (int j = 0; j < R; j++) begin
                if ((r_snap[j] < r_snap[i]) || ((r_snap[j] == r_snap[i]) && (j < i))) begin
                    v_rank = v_rank + RK_W'(1);
                end
            end
            if (v_rank == RK_W'(R / 2)) begin
                w_med = w_med | r_snap[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_med <= w_med;
        end
    end

    // Stage 3: history push; sum covers the new median and the kept entries
    always_comb begin
        w_sum = SUM_W'(r_med);
        for (int g = 1; g < D; g++) begin
            w_sum = w_sum + SUM_W'(r_hist[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < D; g++) begin
                r_hist[g] <= '0;
            end
        end else if (i_ctl.ld3) begin
            for (int g = 0; g < D - 1; g++) begin
                r_hist[g] <= r_hist[g+1];
            end
            r_hist[D-1] <= r_med;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_sum <= w_sum;
        end
    end

    // Stage 4: divide by history depth via reciprocal multiply
    assign w_prod = PROD_W'(r_sum) * PROD_W'(FM);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld4) begin
            r_filt <= w_prod[FK +: DW];
        end
    end

    assign o_filt = r_filt;

endmodule

/* hdl/lsmd_merge.sv */
// ============================================================================
// lsmd_merge
// Combines lane outputs: middle-pair level, deviation test and result register.
// ============================================================================
module lsmd_merge (
    input  logic                          i_clk,
    input  lsmd_pkg::t_pipe_ctl           i_ctl,
    input  lsmd_pkg::t_cfg                i_cfg,
    input  logic [lsmd_pkg::DATA_W-1:0]   i_filt  [lsmd_pkg::CHANNELS],
    output logic [lsmd_pkg::DATA_W-1:0]   o_mask,
    output logic [lsmd_pkg::DATA_W-1:0]   o_level,
    output logic [lsmd_pkg::DATA_W-1:0]   o_filt  [lsmd_pkg::CHANNELS]
);

    localparam int NCH  = lsmd_pkg::CHANNELS;
    localparam int DW   = lsmd_pkg::DATA_W;
    localparam int RK_W = $clog2(NCH);

    logic [DW-1:0] w_lo;
    logic [DW-1:0] w_hi;
    logic [DW-1:0] r_lo;
    logic [DW-1:0] r_hi;
    logic [DW-1:0] r_f5    [NCH];
    logic [DW:0]   w_pair;
    logic [DW-1:0] w_level;
    logic [DW-1:0] w_mask;
    logic [DW-1:0] r_mask;
    logic [DW-1:0] r_level;
    logic [DW-1:0] r_f6    [NCH];

    // Stage 5: rank the eight filtered values, pick the middle two
    always_comb begin
        logic [RK_W-1:0] v_rank;
        w_lo = '0;
        w_hi = '0;
        for (int i = 0; i < NCH; i++) begin
            v_rank = '0;
            for (int j = 0; j < NCH; j++) begin
                if ((i_filt[j] < i_filt[i]) || ((i_filt[j] == i_filt[i]) && (j < i))) begin
                    v_rank = v_rank + RK_W'(1);
                end
            end
            if (v_rank == RK_W'(lsmd_pkg::LEVEL_LO_RANK)) begin
                w_lo = w_lo | i_filt[i];
            end
            if (v_rank == RK_W'(lsmd_pkg::LEVEL_HI_RANK)) begin
                w_hi = w_hi | i_filt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld5) begin
            r_lo <= w_lo;
            r_hi <= w_hi;
            r_f5 <= i_filt;
        end
    end

    // Stage 6: level and per-channel deviation test
    assign w_pair  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_level = w_pair[DW:1];

    always_comb begin
        logic [DW-1:0] v_dev;
        w_mask = '0;
        for (int c = 0; c < NCH; c++) begin
            v_dev = (r_f5[c] > w_level) ? (r_f5[c] - w_level) : (w_level - r_f5[c]);
            w_mask[c] = v_dev > i_cfg.line_thr;
        end
        // forward channel: also needs enable and its own threshold
        v_dev = (r_f5[0] > w_level) ? (r_f5[0] - w_level) : (w_level - r_f5[0]);
        w_mask[0] = w_mask[0] && i_cfg.fwd_en && (v_dev > i_cfg.fwd_thr);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld6) begin
            r_mask  <= w_mask;
            r_level <= w_level;
            r_f6    <= r_f5;
        end
    end

    assign o_mask  = r_mask;
    assign o_level = r_level;
    assign o_filt  = r_f6;

endmodule
